// File: design/bpcc_pkg.sv
package bpcc_pkg;

    // defaults for the top-level parameters
    localparam int MAX_POSITIONS_DEF = 16;
    localparam int COUNT_BITS_DEF    = 32;

    // fixed field widths
    localparam int BASE_W    = 2;
    localparam int BASES     = 4;
    localparam int WEIGHT_W  = 16;
    localparam int POS_W     = 4;
    localparam int VALUE_W   = 48;
    localparam int ACTION_W  = 2;
    localparam int CFG_LEN_W = 5;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // stream payload widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_IDX_SEQ_LEN = 1'b0;
    localparam logic [CFG_LEN_W-1:0] SEQ_LEN_RESET = 5'd16;
    localparam int MIN_LEN = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_RD_PAIR  = 2'd1,
        ACT_RD_MARG  = 2'd2,
        ACT_RD_TOTAL = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_MARG_WR,
        ST_PAIR_RD,
        ST_PAIR_WR,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clear_step;
        logic latch_in;
        logic decode;
        logic marg_wr;
        logic pair_rd;
        logic pair_wr;
        logic rd_capture;
        logic finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic    sweep_last;
        t_action action;
        logic    read_bad;
        logic    pos_zero;
        logic    pair_last;
    } t_dp_sts;

    // width of the effective length and of position compares
    function automatic int len_width(input int max_pos);
        return ($clog2(max_pos + 1) > CFG_LEN_W) ? $clog2(max_pos + 1) : CFG_LEN_W;
    endfunction

endpackage

// File: design/bpcc_regs.sv
module bpcc_regs #(
    parameter int MAX_POSITIONS = bpcc_pkg::MAX_POSITIONS_DEF,
    localparam int LW = bpcc_pkg::len_width(MAX_POSITIONS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [bpcc_pkg::APB_AW-1:0]   i_paddr,
    input  logic [bpcc_pkg::APB_DW-1:0]   i_pwdata,
    output logic [bpcc_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready,
    output logic [LW-1:0]                 o_len
);

    logic [bpcc_pkg::CFG_LEN_W-1:0] r_seq_len;
    logic                           n_seq_len_we;
    logic                           reg_hit;

    assign reg_hit      = (i_paddr[bpcc_pkg::APB_AW-1:2] == bpcc_pkg::REG_IDX_SEQ_LEN);
    assign n_seq_len_we = i_psel & i_penable & i_pwrite & reg_hit;
    assign o_pready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= bpcc_pkg::SEQ_LEN_RESET;
        end else if (n_seq_len_we) begin
            r_seq_len <= i_pwdata[bpcc_pkg::CFG_LEN_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_psel && reg_hit) begin
            o_prdata = bpcc_pkg::APB_DW'(r_seq_len);
        end
    end

    // effective length, clamped to [2, MAX_POSITIONS]
    always_comb begin
        o_len = LW'(r_seq_len);
        if (o_len < LW'(bpcc_pkg::MIN_LEN)) begin
            o_len = LW'(bpcc_pkg::MIN_LEN);
        end else if (o_len > LW'(MAX_POSITIONS)) begin
            o_len = LW'(MAX_POSITIONS);
        end
    end

endmodule

// File: design/bpcc_ctrl.sv
module bpcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    input  bpcc_pkg::t_dp_sts i_sts,
    output bpcc_pkg::t_dp_cmd o_cmd
);

    bpcc_pkg::t_state r_state;
    bpcc_pkg::t_state n_state;
    logic             r_m_valid;
    logic             n_m_valid;
    logic             slot_free;

    assign slot_free  = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bpcc_pkg::ST_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpcc_pkg::ST_CLEAR: begin
                if (i_sts.sweep_last) n_state = bpcc_pkg::ST_IDLE;
            end
            bpcc_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = bpcc_pkg::ST_DECODE;
            end
            bpcc_pkg::ST_DECODE: begin
                unique case (i_sts.action)
                    bpcc_pkg::ACT_ADD: n_state = bpcc_pkg::ST_MARG_WR;
                    bpcc_pkg::ACT_RD_PAIR,
                    bpcc_pkg::ACT_RD_MARG: begin
                        n_state = i_sts.read_bad ? bpcc_pkg::ST_DONE : bpcc_pkg::ST_RD_WAIT;
                    end
                    bpcc_pkg::ACT_RD_TOTAL: n_state = bpcc_pkg::ST_DONE;
                    default: n_state = bpcc_pkg::ST_DONE;
                endcase
            end
            bpcc_pkg::ST_MARG_WR: begin
                n_state = i_sts.pos_zero ? bpcc_pkg::ST_DONE : bpcc_pkg::ST_PAIR_RD;
            end
            bpcc_pkg::ST_PAIR_RD: n_state = bpcc_pkg::ST_PAIR_WR;
            bpcc_pkg::ST_PAIR_WR: begin
                n_state = i_sts.pair_last ? bpcc_pkg::ST_DONE : bpcc_pkg::ST_PAIR_RD;
            end
            bpcc_pkg::ST_RD_WAIT: n_state = bpcc_pkg::ST_DONE;
            bpcc_pkg::ST_DONE: begin
                if (slot_free) n_state = bpcc_pkg::ST_IDLE;
            end
            default: n_state = bpcc_pkg::ST_CLEAR;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        n_m_valid  = r_m_valid && !i_m_tready;
        unique case (r_state)
            bpcc_pkg::ST_CLEAR:   o_cmd.clear_step = 1'b1;
            bpcc_pkg::ST_IDLE: begin
                o_s_tready     = 1'b1;
                o_cmd.latch_in = i_s_tvalid;
            end
            bpcc_pkg::ST_DECODE:  o_cmd.decode     = 1'b1;
            bpcc_pkg::ST_MARG_WR: o_cmd.marg_wr    = 1'b1;
            bpcc_pkg::ST_PAIR_RD: o_cmd.pair_rd    = 1'b1;
            bpcc_pkg::ST_PAIR_WR: o_cmd.pair_wr    = 1'b1;
            bpcc_pkg::ST_RD_WAIT: o_cmd.rd_capture = 1'b1;
            bpcc_pkg::ST_DONE: begin
                o_cmd.finish = slot_free;
                if (slot_free) n_m_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: design/bpcc_dp.sv
module bpcc_dp #(
    parameter int MAX_POSITIONS = bpcc_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_BITS    = bpcc_pkg::COUNT_BITS_DEF,
    localparam int LW = bpcc_pkg::len_width(MAX_POSITIONS)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpcc_pkg::t_dp_cmd                i_cmd,
    output bpcc_pkg::t_dp_sts                o_sts,
    input  logic [LW-1:0]                    i_len,
    input  logic [bpcc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [bpcc_pkg::ACTION_W-1:0]    i_s_tuser,
    output logic [bpcc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic                             o_m_tlast,
    output logic                             o_m_tuser
);

    localparam int PW     = $clog2(MAX_POSITIONS);
    localparam int MDEPTH = MAX_POSITIONS * bpcc_pkg::BASES;
    localparam int MAW    = PW + bpcc_pkg::BASE_W;
    localparam int PDEPTH = MAX_POSITIONS * MAX_POSITIONS * bpcc_pkg::BASES * bpcc_pkg::BASES;
    localparam int PAW    = $clog2(PDEPTH);
    localparam int SW     = ((COUNT_BITS > bpcc_pkg::WEIGHT_W) ?
                             COUNT_BITS : bpcc_pkg::WEIGHT_W) + 1;
    localparam int VW     = (COUNT_BITS > bpcc_pkg::VALUE_W) ? COUNT_BITS : bpcc_pkg::VALUE_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ((p_a * MAX + p_b) * 4 + b_a) * 4 + b_b
    function automatic logic [PAW-1:0] pair_idx(input logic [PW-1:0] p_a,
                                                input logic [1:0]    b_a,
                                                input logic [PW-1:0] p_b,
                                                input logic [1:0]    b_b);
        logic [PAW-1:0] row;
        row = PAW'(p_a) * PAW'(MAX_POSITIONS) + PAW'(p_b);
        return {row[PAW-5:0], b_a, b_b};
    endfunction

    // latched input item
    bpcc_pkg::t_action                r_action;
    logic [bpcc_pkg::BASE_W-1:0]      r_base;
    logic [bpcc_pkg::WEIGHT_W-1:0]    r_weight;
    logic [bpcc_pkg::POS_W-1:0]       r_p1;
    logic [bpcc_pkg::POS_W-1:0]       r_p2;
    logic [bpcc_pkg::BASE_W-1:0]      r_b2;

    // sequence state
    logic [PW-1:0]                    r_pos_cnt;
    logic [bpcc_pkg::WEIGHT_W-1:0]    r_held;
    logic [bpcc_pkg::VALUE_W-1:0]     r_total;

    // working registers
    logic [PW-1:0]                    r_pos;
    logic [PW-1:0]                    r_p;
    logic [PAW-1:0]                   r_pair_addr;
    logic [PAW-1:0]                   r_sweep;
    logic [bpcc_pkg::VALUE_W-1:0]     r_res_value;
    logic                             r_res_bad;
    logic [bpcc_pkg::VALUE_W-1:0]     r_m_value;
    logic                             r_m_last;
    logic                             r_m_bad;

    // memories
    logic [COUNT_BITS-1:0]            r_marg_mem [MDEPTH];
    logic [COUNT_BITS-1:0]            r_pair_mem [PDEPTH];
    logic [bpcc_pkg::BASE_W-1:0]      r_bb_mem   [MAX_POSITIONS];
    logic [COUNT_BITS-1:0]            r_marg_q;
    logic [COUNT_BITS-1:0]            r_pair_q;
    logic [bpcc_pkg::BASE_W-1:0]      r_bb_q;

    logic                             marg_we, marg_re;
    logic [MAW-1:0]                   marg_waddr, marg_raddr;
    logic [COUNT_BITS-1:0]            marg_wdata;
    logic                             pair_we, pair_re;
    logic [PAW-1:0]                   pair_waddr, pair_raddr;
    logic [COUNT_BITS-1:0]            pair_wdata;
    logic                             bb_we, bb_re;
    logic [PW-1:0]                    bb_waddr, bb_raddr;

    logic [PW-1:0]                    pos_start;
    logic [PW-1:0]                    p_next;
    logic                             p1_ok, p2_ok, read_bad, seq_last;
    logic [PAW-1:0]                   loop_addr;
    logic [SW-1:0]                    pair_sum;
    logic [COUNT_BITS-1:0]            pair_sat;
    logic [COUNT_BITS-1:0]            marg_sat;
    logic [bpcc_pkg::VALUE_W:0]       total_sum;
    logic [bpcc_pkg::VALUE_W-1:0]     total_sat;
    logic [COUNT_BITS-1:0]            rd_word;
    logic [VW-1:0]                    rd_ext;
    logic [bpcc_pkg::VALUE_W-1:0]     rd_clip;

    // a shrunk length abandons the partial sequence
    assign pos_start = (LW'(r_pos_cnt) >= i_len) ? '0 : r_pos_cnt;
    assign p_next    = r_p + PW'(1);
    assign seq_last  = (LW'(r_pos) + LW'(1)) >= i_len;

    assign p1_ok = LW'(r_p1) < i_len;
    assign p2_ok = LW'(r_p2) < i_len;

    always_comb begin
        case (r_action)
            bpcc_pkg::ACT_RD_PAIR: read_bad = !(p1_ok && p2_ok && (r_p1 < r_p2));
            bpcc_pkg::ACT_RD_MARG: read_bad = !p1_ok;
            default:               read_bad = 1'b0;
        endcase
    end

    assign loop_addr = pair_idx(r_p, r_bb_q, r_pos, r_base);

    // saturating updates
    assign marg_sat  = (r_marg_q == COUNT_MAX) ? r_marg_q : r_marg_q + COUNT_BITS'(1);
    assign pair_sum  = SW'(r_pair_q) + SW'(r_held);
    assign pair_sat  = (pair_sum > SW'(COUNT_MAX)) ? COUNT_MAX : pair_sum[COUNT_BITS-1:0];
    assign total_sum = {1'b0, r_total} + (bpcc_pkg::VALUE_W + 1)'(r_held);
    assign total_sat = total_sum[bpcc_pkg::VALUE_W] ? bpcc_pkg::VALUE_MAX
                                                    : total_sum[bpcc_pkg::VALUE_W-1:0];

    // wide counters read back clipped to 48 bits
    assign rd_word = (r_action == bpcc_pkg::ACT_RD_PAIR) ? r_pair_q : r_marg_q;
    assign rd_ext  = VW'(rd_word);
    assign rd_clip = (rd_ext > VW'(bpcc_pkg::VALUE_MAX)) ? bpcc_pkg::VALUE_MAX
                                                         : rd_ext[bpcc_pkg::VALUE_W-1:0];

    assign o_sts.sweep_last = (r_sweep == PAW'(PDEPTH - 1));
    assign o_sts.action     = r_action;
    assign o_sts.read_bad   = read_bad;
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.pair_last  = (p_next == r_pos);

    // memory port steering
    always_comb begin
        marg_we    = 1'b0;
        marg_waddr = {r_pos, r_base};
        marg_wdata = marg_sat;
        marg_re    = 1'b0;
        marg_raddr = {pos_start, r_base};
        pair_we    = 1'b0;
        pair_waddr = r_pair_addr;
        pair_wdata = pair_sat;
        pair_re    = 1'b0;
        pair_raddr = loop_addr;
        bb_we      = 1'b0;
        bb_waddr   = pos_start;
        bb_re      = 1'b0;
        bb_raddr   = p_next;

        if (i_cmd.clear_step) begin
            pair_we    = 1'b1;
            pair_waddr = r_sweep;
            pair_wdata = '0;
            marg_we    = (r_sweep < PAW'(MDEPTH));
            marg_waddr = r_sweep[MAW-1:0];
            marg_wdata = '0;
        end
        if (i_cmd.decode) begin
            case (r_action)
                bpcc_pkg::ACT_ADD: begin
                    marg_re  = 1'b1;
                    bb_we    = 1'b1;
                    bb_re    = 1'b1;
                    bb_raddr = '0;
                end
                bpcc_pkg::ACT_RD_PAIR: begin
                    pair_re    = 1'b1;
                    pair_raddr = pair_idx(PW'(r_p1), r_base, PW'(r_p2), r_b2);
                end
                bpcc_pkg::ACT_RD_MARG: begin
                    marg_re    = 1'b1;
                    marg_raddr = {PW'(r_p1), r_base};
                end
                default: ;
            endcase
        end
        if (i_cmd.marg_wr) marg_we = 1'b1;
        if (i_cmd.pair_rd) begin
            pair_re = 1'b1;
            bb_re   = 1'b1;
        end
        if (i_cmd.pair_wr) pair_we = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (marg_we) r_marg_mem[marg_waddr] <= marg_wdata;
        if (marg_re) r_marg_q <= r_marg_mem[marg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pair_we) r_pair_mem[pair_waddr] <= pair_wdata;
        if (pair_re) r_pair_q <= r_pair_mem[pair_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bb_we) r_bb_mem[bb_waddr] <= r_base;
        if (bb_re) r_bb_q <= r_bb_mem[bb_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= '0;
            r_pos_cnt <= '0;
            r_held    <= '0;
            r_total   <= '0;
        end else begin
            if (i_cmd.clear_step) r_sweep <= r_sweep + PAW'(1);
            if (i_cmd.decode && (r_action == bpcc_pkg::ACT_ADD) && (pos_start == '0)) begin
                r_held <= r_weight;
            end
            if (i_cmd.finish && (r_action == bpcc_pkg::ACT_ADD)) begin
                if (seq_last) begin
                    r_total   <= total_sat;
                    r_pos_cnt <= '0;
                end else begin
                    r_pos_cnt <= r_pos + PW'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= bpcc_pkg::t_action'(i_s_tuser);
            r_base   <= i_s_tdata[1:0];
            r_weight <= i_s_tdata[17:2];
            r_p1     <= i_s_tdata[21:18];
            r_p2     <= i_s_tdata[25:22];
            r_b2     <= i_s_tdata[27:26];
        end
        if (i_cmd.decode) begin
            r_pos       <= pos_start;
            r_p         <= '0;
            r_res_bad   <= read_bad;
            r_res_value <= (r_action == bpcc_pkg::ACT_RD_TOTAL) ? r_total : '0;
        end
        if (i_cmd.pair_rd)    r_pair_addr <= loop_addr;
        if (i_cmd.pair_wr)    r_p         <= p_next;
        if (i_cmd.rd_capture) r_res_value <= rd_clip;
        if (i_cmd.finish) begin
            r_m_value <= r_res_value;
            r_m_last  <= (r_action == bpcc_pkg::ACT_ADD) && seq_last;
            r_m_bad   <= r_res_bad;
        end
    end

    assign o_m_tdata = r_m_value;
    assign o_m_tlast = r_m_last;
    assign o_m_tuser = r_m_bad;

endmodule

// File: design/base_pair_cooccurrence_counter_unit.sv
// Pairwise joint histogram over fixed-length nucleotide sequences. Send one
// base code (A0 C1 G2 T3) per add transfer; the first base of each sequence
// latches its weight. Each add bumps the marginal counter of (position, base)
// by one, adds the held weight to the joint counter of every earlier
// (position, base) of the same sequence paired with this one, and on the
// last base adds the weight to the 48-bit total and flags tlast. All counters
// saturate. Read transfers return a pair, marginal or total counter; reads
// with positions out of range or not strictly ordered return zero with tuser
// set. After reset a clearing pass zeroes the counter memories, with
// s_tready low. An add walks the earlier positions of its sequence in
// order, reading and then writing back the joint counter of each in the
// pair memory. Pair and marginal reads wait on a memory read; total and
// bad reads do not. One item is worked at a time; a finished result may
// wait in the output register while the next item is taken, and a second
// result stalls in the last state until that register frees up.
module base_pair_cooccurrence_counter_unit #(
    parameter int MAX_POSITIONS = bpcc_pkg::MAX_POSITIONS_DEF,
    parameter int COUNT_BITS    = bpcc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] base, [17:2] weight, [21:18] first_position,
    // [25:22] second_position, [27:26] second_base, [31:28] zero
    input  logic [bpcc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [bpcc_pkg::ACTION_W-1:0]   s_tuser,

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [47:0] value
    output logic [bpcc_pkg::M_TDATA_W-1:0]  m_tdata,
    // sequence_done
    output logic                            m_tlast,
    // [0] bad_address
    output logic                            m_tuser,

    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpcc_pkg::APB_AW-1:0]     paddr,
    input  logic [bpcc_pkg::APB_DW-1:0]     pwdata,
    output logic [bpcc_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int LW = bpcc_pkg::len_width(MAX_POSITIONS);

    logic [LW-1:0]     len;   // effective sequence length
    bpcc_pkg::t_dp_cmd cmd;
    bpcc_pkg::t_dp_sts sts;

    // sequence_length register, clamped to [2, MAX_POSITIONS]
    bpcc_regs #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_len     (len)
    );

    // sequencer: clearing pass, add loop, reads, output handshake
    bpcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // counter memories, sequence state and result register
    bpcc_dp #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_len     (len),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast),
        .o_m_tuser (m_tuser)
    );

endmodule
